### rtl/pwmpd_pkg.sv
// Package with the shared types and constants of the PWM prescaler and duty calculator.
package pwmpd_pkg;

    localparam int DIV_W  = 27;
    localparam int DUTY_W = 10;
    localparam int CNT_W  = $clog2(DIV_W);

    localparam logic [DIV_W-1:0]  MIN_TICKS       = DIV_W'(100);
    localparam logic [DIV_W-1:0]  MAX_TICKS       = DIV_W'(65535);
    localparam logic [DIV_W-1:0]  PERMILLE_FULL   = DIV_W'(1000);
    localparam logic [15:0]       FALLBACK_PERIOD = 16'hFFFF;
    localparam logic [2:0]        FALLBACK_CODE   = 3'd7;
    localparam logic [DIV_W-1:0]  CLOCK_RESET     = DIV_W'(60000000);

    localparam logic CMD_PERIOD = 1'b0;
    localparam logic CMD_DUTY   = 1'b1;

    typedef struct packed {
        logic              command;
        logic [DIV_W-1:0]  target_freq_hz;
        logic [DUTY_W-1:0] duty_permille;
        logic              channel;
    } t_cmd_item;

    typedef struct packed {
        logic        result_kind;
        logic [15:0] period_minus_one;
        logic [2:0]  prescale_code;
        logic [16:0] compare_value;
        logic        channel_out;
    } t_result_item;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

endpackage

### rtl/pwmpd_serial_div.sv
// Restoring divider that produces one quotient bit per clock cycle.
module pwmpd_serial_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pwmpd_pkg::t_div_req            i_req,
    output logic                           o_done,
    output logic [pwmpd_pkg::DIV_W-1:0]    o_quotient
);

    logic                          r_run, n_run;
    logic                          r_done, n_done;
    logic [pwmpd_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic [pwmpd_pkg::DIV_W-1:0]   r_rem, n_rem;
    logic [pwmpd_pkg::DIV_W-1:0]   r_quo, n_quo;
    logic [pwmpd_pkg::DIV_W-1:0]   r_dvs, n_dvs;
    logic [pwmpd_pkg::DIV_W:0]     w_trial;
    logic [pwmpd_pkg::DIV_W:0]     w_diff;

    assign w_trial = {r_rem, r_quo[pwmpd_pkg::DIV_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_comb begin
        n_run  = r_run;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_req.start) begin
            n_run = 1'b1;
            n_cnt = '0;
            n_rem = '0;
            n_quo = i_req.dividend;
            n_dvs = i_req.divisor;
        end else if (r_run) begin
            // Trial subtraction decides the next quotient bit.
            if (w_trial >= {1'b0, r_dvs}) begin
                n_rem = w_diff[pwmpd_pkg::DIV_W-1:0];
                n_quo = {r_quo[pwmpd_pkg::DIV_W-2:0], 1'b1};
            end else begin
                n_rem = w_trial[pwmpd_pkg::DIV_W-1:0];
                n_quo = {r_quo[pwmpd_pkg::DIV_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + pwmpd_pkg::CNT_W'(1);
            if (r_cnt == pwmpd_pkg::CNT_W'(pwmpd_pkg::DIV_W - 1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

### rtl/pwm_prescale_and_duty_calc_top.sv
// Top level of the PWM prescaler, period and duty compare calculator.
// A zero frequency goes straight to the result, a period command runs the bit-serial
// divider and then the prescaler search, and a duty command runs the serial multiply and
// then the divider. The next command is accepted at the edge that ends the strobe cycle;
// the receiver cannot stall. Synchronous active-low reset restores 60 MHz and zeros the
// stored period and prescaler code.
module pwm_prescale_and_duty_calc_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  pwmpd_pkg::t_cmd_item       i_item,
    output logic                       o_result_strobe,
    output pwmpd_pkg::t_result_item    o_result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    // One-hot sequencer states.
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_DIV  = 5'b00100,
        S_SEL  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state                          r_state, n_state;
    logic [pwmpd_pkg::DIV_W-1:0]     r_clk_hz;
    logic                            r_cmd, n_cmd;
    logic                            r_chan, n_chan;
    logic [pwmpd_pkg::DIV_W-1:0]     r_mcand, n_mcand;
    logic [pwmpd_pkg::DUTY_W-1:0]    r_mplier, n_mplier;
    logic [pwmpd_pkg::DIV_W-1:0]     r_acc, n_acc;
    logic [3:0]                      r_cnt, n_cnt;
    logic [pwmpd_pkg::DIV_W-1:0]     r_q, n_q;
    logic [16:0]                     r_full, n_full;
    logic [16:0]                     r_cv, n_cv;
    logic [15:0]                     r_period, n_period;
    logic [2:0]                      r_code, n_code;
    pwmpd_pkg::t_div_req             r_div_req, n_div_req;
    pwmpd_pkg::t_result_item         r_result, n_result;
    logic                            r_strobe, n_strobe;
    logic                            w_div_done;
    logic [pwmpd_pkg::DIV_W-1:0]     w_div_quo;
    logic                            w_accept;
    logic                            w_cfg_write;
    logic                            w_in_range;

    // Configuration port: the clock register sits at byte address 0, writes complete
    // in the access cycle since the port never inserts wait states.
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign prdata      = (paddr[2] == 1'b0) ? {5'd0, r_clk_hz} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_hz <= pwmpd_pkg::CLOCK_RESET;
        end else if (w_cfg_write) begin
            r_clk_hz <= pwdata[pwmpd_pkg::DIV_W-1:0];
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    // A tick count qualifies when it lies between the minimum and the 16-bit maximum.
    assign w_in_range = (r_q >= pwmpd_pkg::MIN_TICKS) && (r_q <= pwmpd_pkg::MAX_TICKS);

    // The single divider serves both commands: clock over frequency for a period
    // command, and the duty product over one thousand for a duty command.
    pwmpd_serial_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (r_div_req),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    always_comb begin
        n_state          = r_state;
        n_cmd            = r_cmd;
        n_chan           = r_chan;
        n_mcand          = r_mcand;
        n_mplier         = r_mplier;
        n_acc            = r_acc;
        n_cnt            = r_cnt;
        n_q              = r_q;
        n_full           = r_full;
        n_cv             = r_cv;
        n_period         = r_period;
        n_code           = r_code;
        n_div_req        = r_div_req;
        n_div_req.start  = 1'b0;
        n_result         = r_result;
        n_strobe         = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd  = i_item.command;
                    n_chan = i_item.channel;
                    n_cv   = '0;
                    n_cnt  = '0;
                    if (i_item.command == pwmpd_pkg::CMD_PERIOD) begin
                        if (i_item.target_freq_hz == '0) begin
                            // A zero frequency skips the division and stores the fallback.
                            n_period = pwmpd_pkg::FALLBACK_PERIOD;
                            n_code   = pwmpd_pkg::FALLBACK_CODE;
                            n_state  = S_FIN;
                        end else begin
                            n_div_req.start    = 1'b1;
                            n_div_req.dividend = r_clk_hz;
                            n_div_req.divisor  = i_item.target_freq_hz;
                            n_state            = S_DIV;
                        end
                    end else begin
                        // Duty: multiply (period + 1) by the duty, one duty bit a cycle.
                        n_full   = {1'b0, r_period} + 17'd1;
                        n_mcand  = {11'd0, r_period} + 27'd1;
                        n_mplier = i_item.duty_permille;
                        n_acc    = '0;
                        n_state  = S_MUL;
                    end
                end
            end
            S_MUL: begin
                if (r_mplier[0]) begin
                    n_acc = r_acc + r_mcand;
                end
                n_mcand  = {r_mcand[pwmpd_pkg::DIV_W-2:0], 1'b0};
                n_mplier = {1'b0, r_mplier[pwmpd_pkg::DUTY_W-1:1]};
                n_cnt    = r_cnt + 4'd1;
                if (r_cnt == 4'(pwmpd_pkg::DUTY_W - 1)) begin
                    n_div_req.start    = 1'b1;
                    n_div_req.dividend = n_acc;
                    n_div_req.divisor  = pwmpd_pkg::PERMILLE_FULL;
                    n_state            = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_cnt = '0;
                    if (r_cmd == pwmpd_pkg::CMD_PERIOD) begin
                        n_q     = w_div_quo;
                        n_state = S_SEL;
                    end else begin
                        // A duty above full scale saturates at period + 1.
                        if (w_div_quo > {10'd0, r_full}) begin
                            n_cv = r_full;
                        end else begin
                            n_cv = w_div_quo[16:0];
                        end
                        n_state = S_FIN;
                    end
                end
            end
            S_SEL: begin
                // Each step halves the tick count, which is the next prescaler code.
                if (w_in_range) begin
                    n_period = r_q[15:0] - 16'd1;
                    n_code   = r_cnt[2:0];
                    n_state  = S_FIN;
                end else if (r_cnt[2:0] == pwmpd_pkg::FALLBACK_CODE) begin
                    n_period = pwmpd_pkg::FALLBACK_PERIOD;
                    n_code   = pwmpd_pkg::FALLBACK_CODE;
                    n_state  = S_FIN;
                end else begin
                    n_q   = {1'b0, r_q[pwmpd_pkg::DIV_W-1:1]};
                    n_cnt = r_cnt + 4'd1;
                end
            end
            S_FIN: begin
                n_result.result_kind      = r_cmd;
                n_result.period_minus_one = r_period;
                n_result.prescale_code    = r_code;
                n_result.compare_value    = r_cv;
                n_result.channel_out      = (r_cmd == pwmpd_pkg::CMD_DUTY) ? r_chan : 1'b0;
                n_strobe                  = 1'b1;
                n_state                   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_strobe        <= 1'b0;
            r_div_req.start <= 1'b0;
            r_period        <= '0;
            r_code          <= '0;
        end else begin
            r_state         <= n_state;
            r_strobe        <= n_strobe;
            r_div_req.start <= n_div_req.start;
            r_period        <= n_period;
            r_code          <= n_code;
        end
        r_cmd              <= n_cmd;
        r_chan             <= n_chan;
        r_mcand            <= n_mcand;
        r_mplier           <= n_mplier;
        r_acc              <= n_acc;
        r_cnt              <= n_cnt;
        r_q                <= n_q;
        r_full             <= n_full;
        r_cv               <= n_cv;
        r_div_req.dividend <= n_div_req.dividend;
        r_div_req.divisor  <= n_div_req.divisor;
        r_result           <= n_result;
    end

    assign o_result_strobe = r_strobe;
    assign o_result        = r_result;

`ifndef SYNTH
    // Every result transfer follows the final sequencer state.
    a_strobe_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> $past(r_state == S_FIN))
        else $error("result strobe without a finishing state");

    // An accepted command keeps the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("command accepted but block not busy");

    // The divider only reports completion while the sequencer waits for it.
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");

    // A duty compare value never exceeds the full period.
    a_compare_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && (o_result.result_kind == pwmpd_pkg::CMD_DUTY)) |->
        (o_result.compare_value <= ({1'b0, o_result.period_minus_one} + 17'd1)))
        else $error("compare value above period plus one");
`endif

endmodule

### tb/pwm_prescale_and_duty_calc_top_test.sv
// Self-checking testbench for the PWM prescaler, period and duty compare calculator.
`timescale 1ns / 100ps

module pwm_prescale_and_duty_calc_top_test;

    // The clock register is the only register and sits at byte address zero.
    localparam logic [2:0] ADDR_INPUT_CLOCK = 3'd0;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned ITEMS_PER_PHASE = 80;

    // Timer settings board: tracks the stored period, the stored prescaler code and the
    // clock register, works out the setting each accepted command must produce and checks
    // the block's results against them in order.
    class timer_setting_board;
        pwmpd_pkg::t_result_item owed_settings[$];
        logic [26:0]  timer_clk_hz;
        logic [15:0]  held_period;
        logic [2:0]   held_code;
        int unsigned  mismatch_count;

        function new();
            timer_clk_hz = 27'(60000000);
            held_period = '0;
            held_code = '0;
            mismatch_count = 0;
        endfunction

        function void set_clock(logic [26:0] hz);
            timer_clk_hz = hz;
        endfunction

        function void log_command(pwmpd_pkg::t_cmd_item cmd);
            pwmpd_pkg::t_result_item want;
            logic [31:0]  ticks;
            logic [31:0]  full_scale;
            logic [31:0]  cmp;
            logic [15:0]  period;
            logic [2:0]   code;
            int           c;
            bit           found;

            want = '0;
            if (cmd.command == pwmpd_pkg::CMD_PERIOD) begin
                period = 16'hFFFF;
                code = 3'd7;
                found = 1'b0;
                // A zero frequency skips the search and keeps the fallback setting.
                if (cmd.target_freq_hz != '0) begin
                    for (c = 0; c < 8 && !found; c++) begin
                        ticks = (32'(timer_clk_hz) >> c) / 32'(cmd.target_freq_hz);
                        if (ticks >= 32'd100 && ticks <= 32'd65535) begin
                            period = 16'(ticks - 32'd1);
                            code = 3'(c);
                            found = 1'b1;
                        end
                    end
                end
                held_period = period;
                held_code = code;
                want.result_kind = pwmpd_pkg::CMD_PERIOD;
            end else begin
                full_scale = 32'(held_period) + 32'd1;
                cmp = (full_scale * 32'(cmd.duty_permille)) / 32'd1000;
                if (cmp > full_scale) begin
                    cmp = full_scale;
                end
                want.result_kind = pwmpd_pkg::CMD_DUTY;
                want.compare_value = 17'(cmp);
                want.channel_out = cmd.channel;
            end
            want.period_minus_one = held_period;
            want.prescale_code = held_code;
            owed_settings.push_back(want);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatch_count++;
            end
        endfunction

        function void check_setting(pwmpd_pkg::t_result_item got);
            pwmpd_pkg::t_result_item want;
            if (owed_settings.size() == 0) begin
                $error("result with nothing owed: kind %0d period %0d code %0d compare %0d",
                       got.result_kind, got.period_minus_one, got.prescale_code,
                       got.compare_value);
                mismatch_count++;
            end else begin
                want = owed_settings.pop_front();
                compare_field("result_kind", want.result_kind, got.result_kind);
                compare_field("period_minus_one", want.period_minus_one, got.period_minus_one);
                compare_field("prescale_code", want.prescale_code, got.prescale_code);
                compare_field("compare_value", want.compare_value, got.compare_value);
                compare_field("channel_out", want.channel_out, got.channel_out);
            end
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    pwmpd_pkg::t_cmd_item    i_item;
    logic                    o_result_strobe;
    pwmpd_pkg::t_result_item o_result;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [2:0]              paddr;
    logic [31:0]             pwdata;
    logic [31:0]             prdata;
    logic                    pready;

    timer_setting_board board = new();
    int unsigned cycle_count = 0;

    pwm_prescale_and_duty_calc_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_item          (i_item),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Results cannot be held off, so every strobe is a completed transfer and is checked
    // at the edge that ends its cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_strobe) begin
            board.check_setting(o_result);
        end
    end

    // A hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic pwmpd_pkg::t_cmd_item make_period(logic [26:0] freq);
        pwmpd_pkg::t_cmd_item cmd;
        cmd.command = pwmpd_pkg::CMD_PERIOD;
        cmd.target_freq_hz = freq;
        cmd.duty_permille = 10'($urandom);
        cmd.channel = 1'($urandom);
        return cmd;
    endfunction

    function automatic pwmpd_pkg::t_cmd_item make_duty(logic [9:0] duty, logic chan);
        pwmpd_pkg::t_cmd_item cmd;
        cmd.command = pwmpd_pkg::CMD_DUTY;
        cmd.target_freq_hz = 27'($urandom);
        cmd.duty_permille = duty;
        cmd.channel = chan;
        return cmd;
    endfunction

    // Random period commands lean toward frequencies that land inside the prescaler
    // search, so that every code and a wide spread of periods are reached; the rest is
    // the zero frequency, uniform values, very low frequencies and raw 27-bit patterns.
    function automatic pwmpd_pkg::t_cmd_item random_command(logic [26:0] hz);
        int unsigned pick;
        int unsigned code;
        int unsigned ticks;
        logic [26:0] freq;
        logic [9:0]  duty;

        if ($urandom_range(99) < 40) begin
            pick = $urandom_range(99);
            if (pick < 3) begin
                freq = '0;
            end else if (pick < 60) begin
                code = $urandom_range(7);
                ticks = $urandom_range(90, 66000);
                freq = 27'((32'(hz) >> code) / ticks);
                if (freq == '0) begin
                    freq = 27'($urandom_range(1, 5));
                end
            end else if (pick < 85) begin
                freq = 27'($urandom_range(1, 120000000));
            end else if (pick < 95) begin
                freq = 27'($urandom_range(1, 3000));
            end else begin
                freq = 27'($urandom);
            end
            return make_period(freq);
        end
        if ($urandom_range(99) < 70) begin
            duty = 10'($urandom_range(0, 1000));
        end else begin
            duty = 10'($urandom_range(0, 1023));
        end
        return make_duty(duty, 1'($urandom));
    endfunction

    // Idle cycles ahead of a command. Mostly geometric, sometimes a flat spread so that
    // the gap ends at any point of the block's work.
    function automatic int pick_gap(int unsigned idle_pct);
        int gap;
        gap = 0;
        if (idle_pct == 0) begin
            return 0;
        end
        if ($urandom_range(7) == 0) begin
            return $urandom_range(0, 45);
        end
        while ($urandom_range(99) < idle_pct && gap < 200) begin
            gap++;
        end
        return gap;
    endfunction

    // Offers one command and returns at the edge that completes its transfer. Start is
    // left high so that a back-to-back command needs only one assignment per edge.
    task automatic issue_command(input pwmpd_pkg::t_cmd_item cmd, input int gap);
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_item <= cmd;
        forever begin
            @(posedge i_clk);
            if (!busy) begin
                board.log_command(cmd);
                break;
            end
        end
    endtask

    // Holds the sender off until every owed result has arrived and the block is idle.
    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (board.owed_settings.size() != 0) begin
            @(posedge i_clk);
        end
        do begin
            @(posedge i_clk);
        end while (busy);
    endtask

    // Writes the clock register through the bus and reads it back. The upper bits of the
    // write data are random; only the low 27 bits are kept by the block.
    task automatic write_input_clock(input logic [26:0] hz);
        drain_results();
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_INPUT_CLOCK;
        pwdata <= {5'($urandom), hz};
        @(negedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        board.set_clock(hz);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        board.compare_field("clock_register", 32'(hz), prdata);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_random_phase(input logic [26:0] hz, input int unsigned idle_pct);
        write_input_clock(hz);
        for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // Now and then the sender waits for the block to empty completely.
            if ($urandom_range(39) == 0) begin
                drain_results();
            end
            issue_command(random_command(hz), pick_gap(idle_pct));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset clock of 60 MHz. Duty commands before any period command see a period of
        // zero, so the compare value is zero or one.
        issue_command(make_duty(10'd0, 1'b0), 0);
        issue_command(make_duty(10'd1000, 1'b1), 1);
        issue_command(make_duty(10'd1023, 1'b0), 0);
        // A zero frequency gives the full-scale fallback, and a full duty then needs the
        // seventeenth compare bit.
        issue_command(make_period(27'd0), 0);
        issue_command(make_duty(10'd1000, 1'b1), 0);
        issue_command(make_duty(10'd1023, 1'b0), 2);
        // Tick counts just inside and just past both ends of the allowed range.
        issue_command(make_period(27'd600000), 0);
        issue_command(make_period(27'd600001), 0);
        issue_command(make_period(27'd916), 1);
        issue_command(make_period(27'd915), 0);
        issue_command(make_duty(10'd500, 1'b0), 0);
        issue_command(make_duty(10'd1, 1'b1), 0);
        // The largest divider is the only one that fits, then nothing fits at all.
        issue_command(make_period(27'd8), 0);
        issue_command(make_period(27'd7), 0);
        issue_command(make_period(27'd120000000), 0);
        issue_command(make_period(27'h7FFFFFF), 3);
        issue_command(make_period(27'd1000), 0);
        issue_command(make_duty(10'd999, 1'b1), 0);

        // A zero clock makes every tick count zero.
        write_input_clock(27'd0);
        issue_command(make_period(27'd1000), 0);
        issue_command(make_duty(10'd1000, 1'b0), 0);

        // Highest and lowest clock settings.
        write_input_clock(27'd120000000);
        issue_command(make_period(27'd1831), 0);
        issue_command(make_period(27'd1200000), 0);
        issue_command(make_duty(10'd777, 1'b1), 0);
        write_input_clock(27'd1);
        issue_command(make_period(27'd1), 0);

        // Random part: each phase sets its own clock and sender idling.
        run_random_phase(27'd60000000, 0);
        run_random_phase(27'd120000000, 77);
        run_random_phase(27'($urandom_range(1, 120000000)), 0);
        run_random_phase(27'd24000000, 33);
        run_random_phase(27'($urandom_range(1, 120000000)), 77);

        drain_results();
        repeat (50) @(posedge i_clk);
        if (board.owed_settings.size() != 0) begin
            $error("%0d expected results never arrived", board.owed_settings.size());
            board.mismatch_count++;
        end
        if (board.mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
